### hw/rtl/qts_pkg.sv
// Shared types, constants and helper functions for the quoted token splitter.
// Used by qts_front, qts_queue, qts_back and quoted_token_splitter.
package qts_pkg;

    localparam int MAX_DELIMITERS = 8;
    localparam int DELIM_W        = 8 * MAX_DELIMITERS;
    localparam int DCNT_W         = 4;
    localparam int FLAGS_W        = 3;
    localparam int CFG_IDX_W      = 2;

    // Action queue between front and back.
    localparam int QDEPTH = 2;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = Q_AW + 1;

    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] SQUOTE_BYTE    = 8'h27;
    localparam logic [7:0] DQUOTE_BYTE    = 8'h22;
    localparam logic [7:0] NUL_BYTE       = 8'h00;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_FLAGS   = 2'd2;

    localparam logic [DELIM_W-1:0] DELIM_BYTES_RST = 64'h2020_2020_0000_0200;
    localparam logic [DCNT_W-1:0]  DELIM_COUNT_RST = 4'd2;
    localparam logic [FLAGS_W-1:0] ESC_FLAGS_RST   = 3'd7;

    // Escape flag bit positions.
    localparam int FLAG_BSLASH = 0;
    localparam int FLAG_SQUOTE = 1;
    localparam int FLAG_DQUOTE = 2;

    typedef enum logic {
        ACT_TAKE   = 1'b0,
        ACT_FINISH = 1'b1
    } t_act;

    typedef struct packed {
        t_act       kind;
        logic [7:0] data;
        logic       first;
    } t_qent;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // True when b matches one of the active delimiter slots. A NUL never matches.
    function automatic logic is_delim(input logic [7:0]         b,
                                      input logic [DELIM_W-1:0] bytes,
                                      input logic [DCNT_W-1:0]  count);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < MAX_DELIMITERS; k++) begin
            if ((count > DCNT_W'(k)) && (bytes[8*k +: 8] == b)) begin
                hit = 1'b1;
            end
        end
        return hit && (b != NUL_BYTE);
    endfunction

endpackage

### hw/rtl/qts_front.sv
// Front end of the quoted token splitter: configuration registers, byte
// classification and tokenizer state. Depends on qts_pkg.
module qts_front
    import qts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELIM_W-1:0]   i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output logic                 o_push,
    output t_qent                o_push_ent
);

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } t_qmode;

    logic [DELIM_W-1:0] r_delim_bytes;
    logic [DCNT_W-1:0]  r_delim_count;
    logic [FLAGS_W-1:0] r_flags;

    logic   r_inside, n_inside;
    t_qmode r_qm, n_qm;
    logic   r_esc, n_esc;

    logic   act_vld;
    t_qent  act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes <= DELIM_BYTES_RST;
            r_delim_count <= DELIM_COUNT_RST;
            r_flags       <= ESC_FLAGS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIM_BYTES: r_delim_bytes <= i_cfg_data;
                CFG_DELIM_COUNT: r_delim_count <= i_cfg_data[DCNT_W-1:0];
                CFG_ESC_FLAGS:   r_flags       <= i_cfg_data[FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic       delim;
        logic       esc_on;
        logic       first_w;
        logic       esc_w;
        logic       fin_w;
        t_qmode     qm_w;
        logic [7:0] closer;

        delim    = is_delim(i_byte, r_delim_bytes, r_delim_count);
        esc_on   = r_flags[FLAG_BSLASH];
        first_w  = 1'b0;
        esc_w    = r_esc;
        qm_w     = r_qm;
        fin_w    = 1'b0;
        closer   = (r_qm == QM_SINGLE) ? SQUOTE_BYTE : DQUOTE_BYTE;

        n_inside = r_inside;
        n_qm     = r_qm;
        n_esc    = r_esc;
        act_vld  = 1'b0;
        act      = '{kind: ACT_TAKE, data: i_byte, first: 1'b0};

        if (i_byte == NUL_BYTE) begin
            act_vld  = 1'b1;
            act.kind = ACT_FINISH;
            n_inside = 1'b0;
            n_qm     = QM_NONE;
            n_esc    = 1'b0;
        end else if (r_inside || !delim) begin
            if (!r_inside) begin
                first_w = 1'b1;
                esc_w   = 1'b0;
                qm_w    = QM_NONE;
            end
            if (esc_w) begin
                esc_w = 1'b0;
            end else if (qm_w != QM_NONE) begin
                if (i_byte == BACKSLASH_BYTE && esc_on) begin
                    esc_w = 1'b1;
                end else if (i_byte == closer) begin
                    qm_w  = QM_NONE;
                    fin_w = delim;
                end
            end else begin
                if (i_byte == BACKSLASH_BYTE && esc_on) begin
                    esc_w = 1'b1;
                end else if (i_byte == SQUOTE_BYTE && r_flags[FLAG_SQUOTE]) begin
                    qm_w = QM_SINGLE;
                end else if (i_byte == DQUOTE_BYTE && r_flags[FLAG_DQUOTE]) begin
                    qm_w = QM_DOUBLE;
                end else begin
                    fin_w = delim;
                end
            end
            act_vld = 1'b1;
            if (fin_w) begin
                act.kind = ACT_FINISH;
                n_inside = 1'b0;
                n_qm     = QM_NONE;
                n_esc    = 1'b0;
            end else begin
                act.first = first_w;
                n_inside  = 1'b1;
                n_qm      = qm_w;
                n_esc     = esc_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_qm     <= QM_NONE;
            r_esc    <= 1'b0;
        end else if (i_accept) begin
            r_inside <= n_inside;
            r_qm     <= n_qm;
            r_esc    <= n_esc;
        end
    end

    assign o_push     = i_accept && act_vld;
    assign o_push_ent = act;

endmodule

### hw/rtl/qts_queue.sv
// Short action queue between the front and back of the quoted token splitter.
// Depends on qts_pkg.
module qts_queue
    import qts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_push_ent,
    input  logic   i_pop,
    output t_qent  o_head,
    output t_qstat o_stat
);

    t_qent           r_mem [QDEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CW'(QDEPTH));

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("action queue pushed while full");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("action queue popped while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(QDEPTH))
        else $error("action queue count out of range");

endmodule

### hw/rtl/qts_back.sv
// Back end of the quoted token splitter: holds one token byte back and
// drives the output register. Depends on qts_pkg.
module qts_back
    import qts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qent      i_head,
    input  t_qstat     i_stat,
    output logic       o_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_token_first,
    output logic       o_token_last,
    input  logic       i_out_stall
);

    logic       r_held_valid;
    logic [7:0] r_held_byte;
    logic       r_held_first;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_first;
    logic       r_out_last;

    logic slot_free;
    logic emit;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = !i_stat.empty && (!r_held_valid || slot_free);
    assign emit      = o_pop && r_held_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (o_pop) begin
            r_held_valid <= (i_head.kind == ACT_TAKE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == ACT_TAKE) begin
            r_held_byte  <= i_head.data;
            r_held_first <= i_head.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= r_held_byte;
            r_out_first <= r_held_first;
            r_out_last  <= (i_head.kind == ACT_FINISH);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_token_first = r_out_first;
    assign o_token_last  = r_out_last;

    // Closing a token with a byte held must release it marked as last.
    a_finish_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_held_valid && i_head.kind == ACT_FINISH)
            |=> (r_out_valid && r_out_last))
        else $error("token end did not release a last byte");

    // Taking a byte always leaves exactly that byte held.
    a_take_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.kind == ACT_TAKE)
            |=> (r_held_valid && r_held_byte == $past(i_head.data)))
        else $error("taken byte not held");

    // A byte is never released while the output register is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot_free)
        else $error("output register overwritten while stalled");

endmodule

### hw/rtl/quoted_token_splitter.sv
// Quoted token splitter: the front pushes the accepted byte that releases a
// token byte into the action queue; the back then moves that token byte into
// the output register. Throughput is one byte per cycle while the output is
// not stalled, set by combinational classification and one pop per cycle.
// Reset (i_rst_n, synchronous, active low) clears all control state and loads
// the default configuration; there is no clearing pass.
module quoted_token_splitter
    import qts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELIM_W-1:0]   i_cfg_data,
    // Input byte stream.
    input  logic                 i_in_valid,
    input  logic [7:0]           i_in_byte,
    output logic                 o_in_stall,
    // Token byte stream.
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_token_first,
    output logic                 o_token_last,
    input  logic                 i_out_stall
);

    // The front classifies each byte and turns it into at most one action:
    // append this byte to the current token, or finish the token. Skipped
    // delimiters produce no action at all.
    logic   accept;
    logic   push;
    t_qent  push_ent;
    logic   pop;
    t_qent  head;
    t_qstat stat;

    // The input request is taken whenever the queue has room. The stall is
    // derived only from the registered queue count, so it never depends on
    // the input valid.
    assign o_in_stall = stat.full;
    assign accept     = i_in_valid && !o_in_stall;

    qts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .o_push      (push),
        .o_push_ent  (push_ent)
    );

    // The queue decouples the two halves, so a stalled output does not stop
    // the front until the queue fills.
    qts_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (stat)
    );

    // The back holds the latest token byte until it knows whether that byte
    // is the token's last, then moves it into the output register.
    qts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_stat        (stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_token_first (o_token_first),
        .o_token_last  (o_token_last),
        .i_out_stall   (i_out_stall)
    );

endmodule
